// ----- hdl/pft_pkg.sv -----
// ----------------------------------------------------------------------------
// pft_pkg
// Shared types and constants of the Pareto filter table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pft_pkg;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int GAMMA_W = 24;
  localparam int OBJ_W   = 48;
  localparam int INF_W   = 47;
  localparam int ENTRY_W = 2 * OBJ_W;
  localparam int FIELD_W = 6;

  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 24'd168;
  localparam logic [GAMMA_W:0]   ONE_Q24     = 25'h100_0000;
  localparam logic [OBJ_W-1:0]   OBJ_MIN     = 48'h8000_0000_0000;

  localparam logic REG_GAMMA_F   = 1'b0;
  localparam logic REG_GAMMA_INF = 1'b1;

  typedef enum logic [1:0] {
    KIND_CHECK   = 2'd0,
    KIND_AUGMENT = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_F,
    ST_MUL_T,
    ST_MARGIN,
    ST_SCAN,
    ST_DRAIN,
    ST_INSERT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic clear_table;
    logic mul_en;
    logic mul_sel;
    logic fb_load;
    logic tb_load;
    logic issue;
    logic insert;
    logic load_result;
  } pft_cmd_t;

  typedef struct packed {
    logic  last_issue;
    kind_t op;
  } pft_stat_t;

endpackage

`default_nettype wire

// ----- hdl/pft_regs.sv -----
// ----------------------------------------------------------------------------
// pft_regs
// APB register file holding the two margin factors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pft_regs import pft_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready,
  output logic [GAMMA_W-1:0]   gamma_f,
  output logic [GAMMA_W-1:0]   gamma_inf
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_f   <= GAMMA_RESET;
      gamma_inf <= GAMMA_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_GAMMA_F) begin
        gamma_f <= pwdata[GAMMA_W-1:0];
      end else begin
        gamma_inf <= pwdata[GAMMA_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_GAMMA_F) begin
      prdata = {{(PDATA_W-GAMMA_W){1'b0}}, gamma_f};
    end else begin
      prdata = {{(PDATA_W-GAMMA_W){1'b0}}, gamma_inf};
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pft_datapath.sv -----
// ----------------------------------------------------------------------------
// pft_datapath
// Entry store, margin multiplier, scan compare and result word registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pft_datapath import pft_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pft_cmd_t             cmd,
  output pft_stat_t            stat,
  input  logic [1:0]           kind,
  input  logic [OBJ_W-1:0]     objective,
  input  logic [INF_W-1:0]     infeasibility,
  input  logic [GAMMA_W-1:0]   gamma_f,
  input  logic [GAMMA_W-1:0]   gamma_inf,
  output logic                 acceptable,
  output logic [FIELD_W-1:0]   entry_count,
  output logic [FIELD_W-1:0]   removed_count,
  output logic                 table_full
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [ENTRY_W-1:0]      mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0]      rd_q;
  logic [TABLE_DEPTH-1:0]  valid;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        removed;

  kind_t                   op;
  logic signed [OBJ_W-1:0] obj_q;
  logic [INF_W-1:0]        inf_q;
  logic                    acc;
  logic                    full;

  logic [GAMMA_W:0]        mul_k;
  logic [OBJ_W-1:0]        prod_hi;
  logic [OBJ_W:0]          prod_lo;
  logic [OBJ_W-1:0]        mul_sum;
  logic [OBJ_W:0]          diff;
  logic signed [OBJ_W-1:0] fb;
  logic [OBJ_W-1:0]        tb;

  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        cmp_idx;
  logic                    cmp_en;
  logic                    vld_q;
  logic [IDX_W-1:0]        free_idx;
  logic                    free_found;

  logic signed [OBJ_W-1:0] rd_obj;
  logic [OBJ_W-1:0]        rd_inf;
  logic                    check_hit;
  logic                    prune_hit;
  logic                    prune_now;

  logic [CNT_W+FIELD_W-1:0] count_ext;
  logic [CNT_W+FIELD_W-1:0] removed_ext;

  assign mul_k   = cmd.mul_sel ? (ONE_Q24 - {1'b0, gamma_inf}) : {1'b0, gamma_f};
  assign mul_sum = prod_hi + OBJ_W'(prod_lo[OBJ_W:GAMMA_W]);
  assign diff    = {obj_q[OBJ_W-1], obj_q} - {1'b0, mul_sum};

  assign rd_obj    = rd_q[ENTRY_W-1:OBJ_W];
  assign rd_inf    = rd_q[OBJ_W-1:0];
  assign check_hit = vld_q && (obj_q >= rd_obj) && ({1'b0, inf_q} >= rd_inf);
  assign prune_hit = vld_q && (rd_obj >= fb) && (rd_inf >= tb);
  assign prune_now = cmp_en && (op == KIND_AUGMENT) && prune_hit;

  assign count_ext   = {{FIELD_W{1'b0}}, count};
  assign removed_ext = {{FIELD_W{1'b0}}, removed};

  assign stat.last_issue = (idx == IDX_W'(TABLE_DEPTH - 1));
  assign stat.op         = op;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      count  <= '0;
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= cmd.issue;
      if (cmd.clear_table) begin
        valid <= '0;
        count <= '0;
      end else if (prune_now) begin
        valid[cmp_idx] <= 1'b0;
        count          <= count - 1'b1;
      end else if (cmd.insert && free_found) begin
        valid[free_idx] <= 1'b1;
        count           <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && free_found) begin
      mem[free_idx] <= {fb, tb};
    end
    if (cmd.issue) begin
      rd_q <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op         <= kind_t'(kind);
      obj_q      <= objective;
      inf_q      <= infeasibility;
      acc        <= (kind_t'(kind) == KIND_CHECK);
      removed    <= '0;
      full       <= 1'b0;
      free_found <= 1'b0;
      idx        <= '0;
    end else begin
      if (cmd.issue) begin
        idx     <= idx + 1'b1;
        cmp_idx <= idx;
        vld_q   <= valid[idx];
      end
      if (cmp_en) begin
        if (op == KIND_CHECK && check_hit) begin
          acc <= 1'b0;
        end
        if (op == KIND_AUGMENT) begin
          if (prune_hit) begin
            removed <= removed + 1'b1;
          end
          if ((!vld_q || prune_hit) && !free_found) begin
            free_idx   <= cmp_idx;
            free_found <= 1'b1;
          end
        end
      end
      if (cmd.insert) begin
        full <= !free_found;
      end
    end

    if (cmd.mul_en) begin
      prod_hi <= {{(OBJ_W-GAMMA_W-1){1'b0}}, mul_k} *
                 {{(OBJ_W-INF_W+GAMMA_W){1'b0}}, inf_q[INF_W-1:GAMMA_W]};
      prod_lo <= {{(OBJ_W-GAMMA_W){1'b0}}, mul_k} *
                 {{(OBJ_W+1-GAMMA_W){1'b0}}, inf_q[GAMMA_W-1:0]};
    end
    if (cmd.fb_load) begin
      if (diff[OBJ_W] && !diff[OBJ_W-1]) begin
        fb <= OBJ_MIN;
      end else begin
        fb <= diff[OBJ_W-1:0];
      end
    end
    if (cmd.tb_load) begin
      tb <= mul_sum;
    end

    if (cmd.load_result) begin
      acceptable    <= acc;
      entry_count   <= count_ext[FIELD_W-1:0];
      removed_count <= removed_ext[FIELD_W-1:0];
      table_full    <= full;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pft_ctrl.sv -----
// ----------------------------------------------------------------------------
// pft_ctrl
// Sequencer: accepts a word, steps margin, scan and insert, hands the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pft_ctrl import pft_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  output logic        out_valid,
  input  logic        out_stall,
  output pft_cmd_t    cmd,
  input  pft_stat_t   stat
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (kind_t'(kind))
            KIND_CHECK:   state_next = ST_SCAN;
            KIND_AUGMENT: state_next = ST_MUL_F;
            default:      state_next = ST_DONE;
          endcase
        end
      end
      ST_MUL_F:  state_next = ST_MUL_T;
      ST_MUL_T:  state_next = ST_MARGIN;
      ST_MARGIN: state_next = ST_SCAN;
      ST_SCAN: begin
        if (stat.last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat.op == KIND_AUGMENT) begin
          state_next = ST_INSERT;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_INSERT: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        cmd.capture     = in_valid;
        cmd.clear_table = in_valid && (kind_t'(kind) == KIND_CLEAR);
      end
      ST_MUL_F: begin
        cmd.mul_en = 1'b1;
      end
      ST_MUL_T: begin
        cmd.fb_load = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = 1'b1;
      end
      ST_MARGIN: begin
        cmd.tb_load = 1'b1;
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
      end
      ST_DONE: begin
        cmd.load_result = !out_valid || !out_stall;
      end
      default: begin
        cmd = '0;
      end
    endcase
    out_valid_next = cmd.load_result || (out_valid && out_stall);
  end

endmodule

`default_nettype wire

// ----- hdl/pareto_filter_table_top.sv -----
// ----------------------------------------------------------------------------
// pareto_filter_table_top
// Filter line search table of (objective, infeasibility) pairs.
//
// Input words carry kind, objective and infeasibility on a valid/stall
// channel; each word yields exactly one result word on the output channel.
// A check word reads the slots one after another through the single read
// port of the entry memory, compares the last slot in the drain state and
// then loads the result register. An augment first forms its margins in
// the multiply and margin states and ends with an insert state. Clear and
// unused kinds go straight to the result load. One word is in work at a
// time, and the next is taken in the cycle after the result loads.
// The result register lets the next word be accepted while the last result
// still waits; a stalled receiver holds the result word and the sequencer
// waits in its final state until the register frees.
// Reset empties the table and restores both margin factors to 168.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pareto_filter_table_top import pft_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           kind,
  input  logic [OBJ_W-1:0]     objective,
  input  logic [INF_W-1:0]     infeasibility,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 acceptable,
  output logic [FIELD_W-1:0]   entry_count,
  output logic [FIELD_W-1:0]   removed_count,
  output logic                 table_full
);

  logic [GAMMA_W-1:0] gamma_f;
  logic [GAMMA_W-1:0] gamma_inf;
  pft_cmd_t           cmd;
  pft_stat_t          stat;

  pft_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .gamma_f   (gamma_f),
    .gamma_inf (gamma_inf)
  );

  pft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  pft_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .kind          (kind),
    .objective     (objective),
    .infeasibility (infeasibility),
    .gamma_f       (gamma_f),
    .gamma_inf     (gamma_inf),
    .acceptable    (acceptable),
    .entry_count   (entry_count),
    .removed_count (removed_count),
    .table_full    (table_full)
  );

endmodule

`default_nettype wire

// ----- hdl/pft_checker.sv -----
// ----------------------------------------------------------------------------
// pft_checker
// Port-level checks of the filter table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pft_checker import pft_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               acceptable,
  input  logic [FIELD_W-1:0] entry_count,
  input  logic [FIELD_W-1:0] removed_count,
  input  logic               table_full
);

  localparam logic [FIELD_W-1:0] DEPTH_LOW = FIELD_W'(TABLE_DEPTH);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(entry_count) && $stable(table_full))
    else $error("result word dropped or changed while stalled");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while one is in work");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (TABLE_DEPTH > 63) || (entry_count <= DEPTH_LOW))
    else $error("entry count above table depth");

  a_full_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |->
      removed_count == '0 && !acceptable && entry_count == DEPTH_LOW)
    else $error("refused insert with pruned entries or partial table");

endmodule

bind pareto_filter_table_top pft_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_pft_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .acceptable    (acceptable),
  .entry_count   (entry_count),
  .removed_count (removed_count),
  .table_full    (table_full)
);

`default_nettype wire

// ----- tb/sv/pareto_filter_table_top_test.sv -----
// ----------------------------------------------------------------------------
// pareto_filter_table_top_test
// Self-checking bench for the Pareto filter table.
//
// Check, augment, clear and unused words go in on the valid/stall channel.
// An in-bench table of (objective, infeasibility) pairs forms the expected
// acceptable flag, entry count, pruned count and full flag of each word.
// Results are matched in order. Margin factors are set over APB between
// phases and read back. Stimulus: directed corner words, staircases that
// fill the table to overflow and are then pruned, and clouds of points near
// a trade-off line or near stored entries. Random idling on both sides, one
// long receiver hold-off and a final phase without idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pareto_filter_table_top_test import pft_pkg::*;;

  localparam int TABLE_DEPTH     = 32;
  localparam int LONG_HOLD       = 600;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int SETTLE_CYCLES   = TABLE_DEPTH + 8;
  localparam logic [GAMMA_W-1:0] GAMMA_MAX = '1;

  localparam logic [PADDR_W-1:0] ADDR_GAMMA_F   = {REG_GAMMA_F, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_GAMMA_INF = {REG_GAMMA_INF, 2'b00};

  localparam logic [OBJ_W-1:0] OBJ_MAX   = {1'b0, {(OBJ_W-1){1'b1}}};
  localparam logic [INF_W-1:0] INF_MAX   = {INF_W{1'b1}};
  localparam longint           OBJ_FLOOR = -(longint'(1) << 47);

  typedef struct packed {
    logic               acceptable;
    logic [FIELD_W-1:0] entry_count;
    logic [FIELD_W-1:0] removed_count;
    logic               table_full;
  } filter_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [1:0]         kind          = KIND_CHECK;
  logic [OBJ_W-1:0]   objective     = '0;
  logic [INF_W-1:0]   infeasibility = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic               acceptable;
  logic [FIELD_W-1:0] entry_count;
  logic [FIELD_W-1:0] removed_count;
  logic               table_full;

  // in-bench copy of the table and margin factors
  logic signed [OBJ_W-1:0] front_obj  [TABLE_DEPTH];
  logic [OBJ_W-1:0]        front_inf  [TABLE_DEPTH];
  logic                    front_live [TABLE_DEPTH];
  logic [GAMMA_W-1:0]      margin_f     = GAMMA_RESET;
  logic [GAMMA_W-1:0]      margin_theta = GAMMA_RESET;

  filter_result_t expected_results[$];
  int             mismatch_count = 0;
  int             words_sent     = 0;
  bit             tx_idle_en     = 1'b1;
  logic           rx_idle_en     = 1'b0;
  logic           long_hold_req  = 1'b0;
  int             stall_left     = 0;
  int             idle_cycles    = 0;

  pareto_filter_table_top #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .objective(objective), .infeasibility(infeasibility),
    .out_valid(out_valid), .out_stall(out_stall), .acceptable(acceptable),
    .entry_count(entry_count), .removed_count(removed_count),
    .table_full(table_full)
  );

  always #2 clk = ~clk;

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      front_obj[i]  = '0;
      front_inf[i]  = '0;
      front_live[i] = 1'b0;
    end
  end

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", what);
  endtask

  // floor(x * k / 2^24), k up to 2^24
  function automatic logic [OBJ_W-1:0] scale_q24(logic [INF_W-1:0] x, logic [GAMMA_W:0] k);
    logic [INF_W+GAMMA_W:0] prod;
    prod = x * k;
    return prod[INF_W+GAMMA_W:GAMMA_W];
  endfunction

  task automatic predict_word(kind_t k, logic [OBJ_W-1:0] obj, logic [INF_W-1:0] inf);
    filter_result_t res;
    longint         fb;
    logic [OBJ_W-1:0] tb;
    logic           placed;
    res    = '0;
    placed = 1'b0;
    case (k)
      KIND_CHECK: begin
        res.acceptable = 1'b1;
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (front_live[i] && $signed(obj) >= front_obj[i] && {1'b0, inf} >= front_inf[i])
            res.acceptable = 1'b0;
      end
      KIND_AUGMENT: begin
        fb = longint'($signed(obj)) - longint'(scale_q24(inf, {1'b0, margin_f}));
        if (fb < OBJ_FLOOR) fb = OBJ_FLOOR;
        tb = scale_q24(inf, ONE_Q24 - {1'b0, margin_theta});
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (front_live[i] && longint'(front_obj[i]) >= fb && front_inf[i] >= tb) begin
            front_live[i] = 1'b0;
            res.removed_count++;
          end
        end
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (!placed && !front_live[i]) begin
            front_obj[i]  = fb[OBJ_W-1:0];
            front_inf[i]  = tb;
            front_live[i] = 1'b1;
            placed        = 1'b1;
          end
        end
        res.table_full = !placed;
      end
      KIND_CLEAR: begin
        for (int i = 0; i < TABLE_DEPTH; i++) front_live[i] = 1'b0;
      end
      default: ;
    endcase
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (front_live[i]) res.entry_count++;
    expected_results.push_back(res);
  endtask

  // receiver: random stall bursts, one long hold-off on request
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (long_hold_req) begin
      long_hold_req <= 1'b0;
      out_stall     <= 1'b1;
      stall_left    <= LONG_HOLD - 1;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    filter_result_t want;
    filter_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got = {acceptable, entry_count, removed_count, table_full};
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result word with none expected: acc=%0d cnt=%0d rm=%0d full=%0d",
                                  got.acceptable, got.entry_count, got.removed_count,
                                  got.table_full));
      end else begin
        want = expected_results.pop_front();
        if (got.acceptable !== want.acceptable || got.entry_count !== want.entry_count ||
            got.removed_count !== want.removed_count || got.table_full !== want.table_full)
          report_mismatch($sformatf(
            "expected acc=%0d cnt=%0d rm=%0d full=%0d, got acc=%0d cnt=%0d rm=%0d full=%0d",
            want.acceptable, want.entry_count, want.removed_count, want.table_full,
            got.acceptable, got.entry_count, got.removed_count, got.table_full));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_word(kind_t k, logic [OBJ_W-1:0] obj, logic [INF_W-1:0] inf);
    int gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= k;
    objective     <= obj;
    infeasibility <= inf;
    do @(posedge clk); while (in_stall);
    predict_word(k, obj, inf);
    words_sent++;
  endtask

  task automatic send_point(kind_t k, longint f, longint th);
    if (th < 0) th = 0;
    if (th > longint'(INF_MAX)) th = longint'(INF_MAX);
    send_word(k, f[OBJ_W-1:0], th[INF_W-1:0]);
  endtask

  function automatic logic [OBJ_W-1:0] rand_obj();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[OBJ_W-1:0];
  endfunction

  function automatic logic [INF_W-1:0] rand_inf();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[INF_W-1:0];
  endfunction

  function automatic int pick_live();
    int start;
    int j;
    start = $urandom_range(0, TABLE_DEPTH - 1);
    for (int n = 0; n < TABLE_DEPTH; n++) begin
      j = (start + n) % TABLE_DEPTH;
      if (front_live[j]) return j;
    end
    return -1;
  endfunction

  // hold input low and wait for every outstanding result word
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_GAMMA_F) margin_f = data[GAMMA_W-1:0];
    else if (addr == ADDR_GAMMA_INF) margin_theta = data[GAMMA_W-1:0];
    @(posedge clk);
  endtask

  task automatic apb_read(logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_margins();
    logic [PDATA_W-1:0] value;
    apb_read(ADDR_GAMMA_F, value);
    if (value !== PDATA_W'(margin_f))
      report_mismatch($sformatf("gamma_f read %0h, expected %0h", value, margin_f));
    apb_read(ADDR_GAMMA_INF, value);
    if (value !== PDATA_W'(margin_theta))
      report_mismatch($sformatf("gamma_inf read %0h, expected %0h", value, margin_theta));
  endtask

  task automatic set_margins(logic [GAMMA_W-1:0] gf, logic [GAMMA_W-1:0] gt);
    drain_results();
    apb_write(ADDR_GAMMA_F, PDATA_W'(gf));
    apb_write(ADDR_GAMMA_INF, PDATA_W'(gt));
    check_margins();
  endtask

  // objective rising, infeasibility falling: no word prunes an earlier one,
  // so the table fills; a dominating augment closes the run
  task automatic run_staircase(int steps, bit clear_first);
    longint f0;
    longint th0;
    longint f;
    longint th;
    if (clear_first) send_word(KIND_CLEAR, rand_obj(), rand_inf());
    f0 = -(longint'($urandom_range(0, 1 << 20)) << 20);
    th0 = longint'($urandom_range(1 << 16, 1 << 20)) << 20;
    f  = f0;
    th = th0;
    repeat (steps) begin
      send_point(KIND_AUGMENT, f, th);
      if ($urandom_range(0, 1))
        send_point(KIND_CHECK, f + longint'($urandom_range(0, 2)) - 1,
                   th + longint'($urandom_range(0, 2)) - 1);
      f  += longint'($urandom_range(1, 1 << 20));
      th -= longint'($urandom_range(0, 1 << 26));
    end
    if ($urandom_range(0, 1))
      send_point(KIND_AUGMENT, f0 - th0 - longint'($urandom_range(0, 1 << 20)), 0);
    else
      send_point(KIND_AUGMENT, f0 + (f - f0) / 2, th0 / 4);
  endtask

  task automatic random_word(longint base_f, longint base_th);
    int     pick;
    int     mode;
    int     j;
    kind_t  k;
    longint f;
    longint th;
    pick = $urandom_range(0, 99);
    if (pick < 45) k = KIND_CHECK;
    else if (pick < 96) k = KIND_AUGMENT;
    else if (pick < 98) k = KIND_NONE;
    else k = KIND_CLEAR;
    mode = $urandom_range(0, 9);
    j = pick_live();
    if (mode == 0) begin
      send_word(k, rand_obj(), rand_inf());
    end else if (mode <= 3 && j >= 0) begin
      f  = longint'(front_obj[j]) + longint'($urandom_range(0, 4)) - 2;
      th = longint'(front_inf[j]) + longint'($urandom_range(0, 4)) - 2;
      send_point(k, f, th);
    end else begin
      f  = base_f + longint'($urandom_range(0, 1 << 23)) - (longint'(1) << 22);
      th = base_th - (f - base_f) + longint'($urandom_range(0, 1 << 18));
      send_point(k, f, th);
    end
  endtask

  task automatic test_register_reset();
    check_margins();
  endtask

  task automatic test_directed();
    send_word(KIND_CHECK, '0, '0);
    send_word(KIND_CHECK, OBJ_MAX, INF_MAX);
    send_word(KIND_CHECK, OBJ_MIN, '0);
    send_word(KIND_AUGMENT, '0, '0);
    send_word(KIND_CHECK, '0, '0);
    send_word(KIND_CHECK, '1, '0);
    send_word(KIND_CHECK, '0, INF_MAX);
    send_word(KIND_AUGMENT, OBJ_MIN, INF_MAX);
    send_word(KIND_AUGMENT, OBJ_MAX, INF_MAX);
    send_word(KIND_AUGMENT, OBJ_MAX, '0);
    send_word(KIND_NONE, OBJ_MAX, INF_MAX);
    send_word(KIND_CHECK, OBJ_MIN, INF_MAX);
    send_word(KIND_AUGMENT, OBJ_MIN, '0);
    send_word(KIND_CHECK, OBJ_MIN, '0);
    send_word(KIND_CHECK, OBJ_MAX, INF_MAX);
    send_word(KIND_CLEAR, OBJ_MAX, INF_MAX);
    send_word(KIND_CHECK, OBJ_MIN, '0);
    send_word(KIND_NONE, '0, '0);
    send_word(KIND_AUGMENT, 48'hAAAA_AAAA_AAAA, 47'h5555_5555_5555);
    send_word(KIND_AUGMENT, 48'h5555_5555_5555, 47'h2AAA_AAAA_AAAA);
    send_word(KIND_CHECK, 48'h7FFF_FFFF_FFFF, '0);
    send_word(KIND_CLEAR, '0, '0);
  endtask

  task automatic test_table_full();
    set_margins('0, '0);
    run_staircase(TABLE_DEPTH + 3, 1'b1);
    set_margins(GAMMA_RESET, GAMMA_RESET);
    run_staircase(TABLE_DEPTH + 2, 1'b1);
  endtask

  task automatic test_random_phase(logic [GAMMA_W-1:0] gf, logic [GAMMA_W-1:0] gt, int count);
    int     target;
    longint base_f;
    longint base_th;
    set_margins(gf, gt);
    target = words_sent + count;
    while (words_sent < target) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en <= ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) begin
        run_staircase($urandom_range(20, 40), 1'($urandom_range(0, 1)));
      end else begin
        base_f  = (longint'($urandom_range(0, 1 << 21)) << 19) - (longint'(1) << 40);
        base_th = longint'($urandom_range(1 << 11, 1 << 21)) << 19;
        repeat (40) random_word(base_f, base_th);
      end
    end
  endtask

  task automatic test_backpressure();
    longint base_th;
    tx_idle_en = 1'b0;
    long_hold_req <= 1'b1;
    base_th = longint'(1) << 32;
    repeat (12) random_word(0, base_th);
    drain_results();
    tx_idle_en = 1'b1;
  endtask

  task automatic test_final_phase();
    int     target;
    longint base_th;
    drain_results();
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    target = words_sent + 250;
    base_th = longint'(1) << 36;
    while (words_sent < target) begin
      if ($urandom_range(0, 3) == 0) run_staircase($urandom_range(20, 40), 1'b1);
      else repeat (40) random_word(-(longint'(1) << 30), base_th);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    rx_idle_en <= 1'b1;
    test_register_reset();
    test_directed();
    test_table_full();
    test_random_phase(GAMMA_RESET, GAMMA_RESET, 300);
    test_random_phase(GAMMA_MAX, GAMMA_MAX, 250);
    test_random_phase('0, GAMMA_MAX, 250);
    test_random_phase(GAMMA_MAX, '0, 250);
    test_backpressure();
    test_random_phase(GAMMA_W'($urandom_range(0, 32'(GAMMA_MAX))),
                      GAMMA_W'($urandom_range(0, 32'(GAMMA_MAX))), 300);
    test_random_phase(GAMMA_W'($urandom_range(0, 4095)),
                      GAMMA_W'($urandom_range(0, 32'(GAMMA_MAX))), 250);
    set_margins(GAMMA_W'($urandom_range(0, 32'(GAMMA_MAX))),
                GAMMA_W'($urandom_range(0, 32'(GAMMA_MAX))));
    test_final_phase();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
